@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the divider pair search unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check with reset disable
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tdps_pkg.sv @@
// Types and constants of the timer divider pair search unit.
// Depends on nothing; imported by timer_divider_pair_search_unit.
package tdps_pkg;

   localparam int unsigned DIVIDEND_W = 32;
   localparam int unsigned DIVISOR_W  = 33;
   localparam int unsigned STEP_W     = 5;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);
   localparam logic [31:0] SYS_CLK_RESET = 32'd200000000;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV1 = 7'b0000010,
      S_DIV2 = 7'b0000100,
      S_CHK  = 7'b0001000,
      S_DIV3 = 7'b0010000,
      S_CMP  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

endpackage

@@ sv/timer_divider_pair_search_unit.sv @@
// Timer divider pair search: scans prescalers with one shared serial divider.
// Depends on tdps_pkg and assert_macros.svh.
//
// A word on req_ carries a target frequency; the unit scans prescalers p from 0
// to COUNT_MAX and returns the first prescaler/period pair with the smallest
// frequency error, stopping early on an exact match or once the period drops
// to 0. Each prescaler visited costs two restoring divisions plus the check step
// when its period is 0 or out of range, and three restoring divisions on the one
// shared divider plus check and compare steps otherwise; a target of 0 goes
// straight to the output step. req_stall stays high during the scan; the result
// sits in an output register, so the next word is taken while an earlier result
// still waits on rsp_stall.
// csr_wr_en writes sys_clk_hz and may only be used while the unit is idle.
`include "assert_macros.svh"

module timer_divider_pair_search_unit
   import tdps_pkg::*;
#(
   parameter longint unsigned COUNT_MAX = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_target_hz,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_best_prescaler,
   output logic [15:0] rsp_best_period,
   output logic        rsp_found
);

   localparam longint unsigned LIMIT = COUNT_MAX;
   localparam int unsigned PS_W = $clog2(LIMIT + 64'd1);
   localparam logic [PS_W-1:0] PS_LAST = PS_W'(LIMIT);
   localparam logic [DIVIDEND_W:0] LIMIT_N = (DIVIDEND_W + 1)'(LIMIT);

   state_type              state_ff, state_in;
   logic [31:0]            sys_clk_ff, sys_clk_in;
   logic [31:0]            target_ff, target_in;
   logic [PS_W-1:0]        p_ff, p_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [31:0]            clk_ff, clk_in;
   logic [31:0]            n_ff, n_in;
   logic [31:0]            act_ff, act_in;
   logic [31:0]            best_err_ff, best_err_in;
   logic [PS_W-1:0]        best_p_ff, best_p_in;
   logic [31:0]            best_n_ff, best_n_in;
   logic                   have_ff, have_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_p_ff, rsp_p_in;
   logic [15:0]            rsp_n_ff, rsp_n_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic [DIVISOR_W-1:0]   dvs;
   logic [DIVISOR_W:0]     trial;
   logic [DIVISOR_W:0]     diff;
   logic                   ge;
   logic [DIVISOR_W-1:0]   step_rem;
   logic [DIVIDEND_W-1:0]  step_quo;
   logic                   step_last;
   logic [31:0]            err;
   logic                   better;
   logic                   req_take;
   logic                   out_free;
   logic                   in_div;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_div   = (state_ff == S_DIV1) || (state_ff == S_DIV2) || (state_ff == S_DIV3);

   // shared restoring divider: divisor select and one quotient bit per cycle
   always_comb begin
      unique case (state_ff)
         S_DIV1:  dvs = DIVISOR_W'(p_ff) + DIVISOR_W'(1);
         S_DIV2:  dvs = DIVISOR_W'(target_ff);
         S_DIV3:  dvs = DIVISOR_W'(n_ff);
         default: dvs = DIVISOR_W'(1);
      endcase
   end

   assign trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff      = trial - {1'b0, dvs};
   assign ge        = trial >= {1'b0, dvs};
   assign step_rem  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   assign step_quo  = {quo_ff[DIVIDEND_W-2:0], ge};
   assign step_last = cnt_ff == STEP_LAST;

   assign err    = (act_ff > target_ff) ? (act_ff - target_ff) : (target_ff - act_ff);
   assign better = !have_ff || (err < best_err_ff);

   always_comb begin
      state_in     = state_ff;
      sys_clk_in   = csr_wr_en ? csr_wr_data : sys_clk_ff;
      target_in    = target_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      clk_in       = clk_ff;
      n_in         = n_ff;
      act_in       = act_ff;
      best_err_in  = best_err_ff;
      best_p_in    = best_p_ff;
      best_n_in    = best_n_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_p_in     = rsp_p_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               target_in = req_target_hz;
               p_in      = '0;
               have_in   = 1'b0;
               best_p_in = '0;
               best_n_in = '0;
               best_err_in = '0;
               rem_in    = '0;
               cnt_in    = '0;
               quo_in    = sys_clk_ff;
               state_in  = (req_target_hz == 32'd0) ? S_OUT : S_DIV1;
            end
         end
         S_DIV1, S_DIV2, S_DIV3: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + STEP_W'(1);
            if (step_last) begin
               cnt_in = '0;
               rem_in = '0;
               unique case (state_ff)
                  S_DIV1: begin
                     clk_in   = step_quo;
                     state_in = S_DIV2;
                  end
                  S_DIV2: begin
                     n_in     = step_quo;
                     state_in = S_CHK;
                  end
                  default: begin
                     act_in   = step_quo;
                     state_in = S_CMP;
                  end
               endcase
            end
         end
         S_CHK: begin
            quo_in = clk_ff;
            if (n_ff == 32'd0) begin
               state_in = S_OUT;
            end else if ({1'b0, n_ff} > LIMIT_N) begin
               quo_in = sys_clk_ff;
               if (p_ff == PS_LAST) begin
                  state_in = S_OUT;
               end else begin
                  p_in     = p_ff + PS_W'(1);
                  state_in = S_DIV1;
               end
            end else begin
               state_in = S_DIV3;
            end
         end
         S_CMP: begin
            quo_in = sys_clk_ff;
            if (better) begin
               have_in     = 1'b1;
               best_err_in = err;
               best_p_in   = p_ff;
               best_n_in   = n_ff;
            end
            if ((better && err == 32'd0) || p_ff == PS_LAST) begin
               state_in = S_OUT;
            end else begin
               p_in     = p_ff + PS_W'(1);
               state_in = S_DIV1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_p_in     = 16'(best_p_ff);
               rsp_n_in     = 16'(best_n_ff);
               rsp_found_in = have_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sys_clk_ff   <= SYS_CLK_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sys_clk_ff   <= sys_clk_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      p_ff         <= p_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      clk_ff       <= clk_in;
      n_ff         <= n_in;
      act_ff       <= act_in;
      best_err_ff  <= best_err_in;
      best_p_ff    <= best_p_in;
      best_n_ff    <= best_n_in;
      have_ff      <= have_in;
      rsp_p_ff     <= rsp_p_in;
      rsp_n_ff     <= rsp_n_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign req_stall          = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_prescaler = rsp_p_ff;
   assign rsp_best_period    = rsp_n_ff;
   assign rsp_found          = rsp_found_ff;

   `ASSERT_CLK(a_cnt_idle, clock, reset, !in_div |-> cnt_ff == '0, "divider step count left nonzero")
   `ASSERT_CLK(a_take_busy, clock, reset, req_take |=> state_ff != S_IDLE, "search did not start")
   `ASSERT_CLK(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT), "result outside output step")

endmodule
